// ===== sv/mks_pkg.sv =====
// Package for the Morse keying sequencer: descriptor types, back-end states,
// register indexes and the character classification function. No dependencies.
package mks_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int UNIT_W     = 10;
	localparam int DUR_W      = 16;
	localparam int CHAR_W     = 8;
	localparam int CNT_W      = 3;
	localparam int BITS_W     = 5;

	localparam logic [UNIT_W-1:0] UNIT_RST       = UNIT_W'(50);
	localparam logic [DUR_W-1:0]  WARMUP_ON_RST  = DUR_W'(2000);
	localparam logic [DUR_W-1:0]  WARMUP_OFF_RST = DUR_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_UNIT       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_ON  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_OFF = CFG_IDX_W'(2);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;

	typedef enum logic [1:0] {
		KIND_PATTERN,
		KIND_SPACE,
		KIND_PREAMBLE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CNT_W-1:0]  count;
		logic [BITS_W-1:0] bits;
	} desc_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_ms;
		logic [DUR_W-1:0]  warmup_on_ms;
		logic [DUR_W-1:0]  warmup_off_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PRE_ON,
		BK_PRE_OFF,
		BK_SPACE,
		BK_ON,
		BK_OFF,
		BK_GAP
	} bk_state_t;

	// Element count and dash mask (first element in bit 0) for A to Z.
	function automatic logic [CNT_W+BITS_W-1:0] letter_pattern(input logic [4:0] idx);
		logic [CNT_W+BITS_W-1:0] p;
		unique case (idx)
			5'd0:  p = {3'd2, 5'h02};
			5'd1:  p = {3'd4, 5'h01};
			5'd2:  p = {3'd4, 5'h05};
			5'd3:  p = {3'd3, 5'h01};
			5'd4:  p = {3'd1, 5'h00};
			5'd5:  p = {3'd4, 5'h04};
			5'd6:  p = {3'd3, 5'h03};
			5'd7:  p = {3'd4, 5'h00};
			5'd8:  p = {3'd2, 5'h00};
			5'd9:  p = {3'd4, 5'h0E};
			5'd10: p = {3'd3, 5'h05};
			5'd11: p = {3'd4, 5'h02};
			5'd12: p = {3'd2, 5'h03};
			5'd13: p = {3'd2, 5'h01};
			5'd14: p = {3'd3, 5'h07};
			5'd15: p = {3'd4, 5'h06};
			5'd16: p = {3'd4, 5'h0B};
			5'd17: p = {3'd3, 5'h02};
			5'd18: p = {3'd3, 5'h00};
			5'd19: p = {3'd1, 5'h01};
			5'd20: p = {3'd3, 5'h04};
			5'd21: p = {3'd4, 5'h08};
			5'd22: p = {3'd3, 5'h06};
			5'd23: p = {3'd4, 5'h09};
			5'd24: p = {3'd4, 5'h0D};
			5'd25: p = {3'd4, 5'h03};
			default: p = '0;
		endcase
		return p;
	endfunction

	// Digits all have five elements; only the dash mask differs.
	function automatic logic [BITS_W-1:0] digit_bits(input logic [3:0] idx);
		logic [BITS_W-1:0] b;
		unique case (idx)
			4'd0: b = 5'h1F;
			4'd1: b = 5'h1E;
			4'd2: b = 5'h1C;
			4'd3: b = 5'h18;
			4'd4: b = 5'h10;
			4'd5: b = 5'h00;
			4'd6: b = 5'h01;
			4'd7: b = 5'h03;
			4'd8: b = 5'h07;
			4'd9: b = 5'h0F;
			default: b = '0;
		endcase
		return b;
	endfunction

	function automatic desc_t classify(input logic cmd, input logic [CHAR_W-1:0] ch);
		desc_t d;
		logic [CHAR_W-1:0] up;
		logic [CHAR_W-1:0] off;
		logic [CNT_W+BITS_W-1:0] lp;
		d  = '{kind: KIND_PATTERN, count: '0, bits: '0};
		up = ch;
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			up = ch - CASE_FOLD;
		end
		if (cmd) begin
			d.kind = KIND_PREAMBLE;
		end else if (ch == CH_SPACE) begin
			d.kind = KIND_SPACE;
		end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
			off     = up - CH_UPPER_A;
			lp      = letter_pattern(off[4:0]);
			d.count = lp[CNT_W+BITS_W-1:BITS_W];
			d.bits  = lp[BITS_W-1:0];
		end else if (up >= CH_ZERO && up <= CH_NINE) begin
			off     = up - CH_ZERO;
			d.count = CNT_W'(5);
			d.bits  = digit_bits(off[3:0]);
		end
		return d;
	endfunction

endpackage

// ===== sv/mks_if.sv =====
// Handshake interfaces for the character requests and the keying segments.
// Depends on mks_pkg for the field widths.
interface mks_chr_if import mks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output cmd, output char_code, input ready);
	modport sink (input valid, input cmd, input char_code, output ready);
endinterface

interface mks_seg_if import mks_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             key_on;
	logic [DUR_W-1:0] duration_ms;
	logic             last;

	modport source (output valid, output key_on, output duration_ms, output last, input ready);
	modport sink (input valid, input key_on, input duration_ms, input last, output ready);
endinterface

// ===== sv/mks_front.sv =====
// Front end: accepts character requests and classifies each into a descriptor.
// Depends on mks_pkg and mks_chr_if.
module mks_front import mks_pkg::*; (
	mks_chr_if.sink chr,
	input  logic    q_full,
	output logic    push,
	output desc_t   desc
);

	assign chr.ready = !q_full;
	assign push      = chr.valid && !q_full;
	assign desc      = classify(chr.cmd, chr.char_code);

endmodule

// ===== sv/mks_queue.sv =====
// Short descriptor queue between the front and back ends.
// Depends on mks_pkg.
module mks_queue import mks_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wr_desc,
	output logic  full,
	input  logic  pop,
	output logic  rd_valid,
	output desc_t rd_desc
);

	desc_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	localparam logic [Q_PTR_W-1:0] PtrLast = Q_PTR_W'(Q_DEPTH - 1);
	localparam logic [Q_CNT_W-1:0] CntFull = Q_CNT_W'(Q_DEPTH);

	assign full     = (cnt_q == CntFull);
	assign rd_valid = (cnt_q != '0);
	assign rd_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mks_back.sv =====
// Back end: walks one descriptor at a time and emits its keying segments
// through an output register. Depends on mks_pkg and mks_seg_if.
module mks_back import mks_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_valid,
	input  desc_t    q_desc,
	output logic     pop,
	mks_seg_if.source seg
);

	bk_state_t         state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [BITS_W-1:0] bits_q;
	logic              out_valid_q;
	logic              key_q;
	logic [DUR_W-1:0]  dur_q;
	logic              last_q;

	logic              adv;
	logic              emit;
	logic              step;
	logic              key_d;
	logic [DUR_W-1:0]  dur_d;
	logic              last_d;
	logic [UNIT_W+1:0] u_ext;
	logic [DUR_W-1:0]  dur_1u;
	logic [DUR_W-1:0]  dur_2u;
	logic [DUR_W-1:0]  dur_3u;
	logic [DUR_W-1:0]  dur_4u;

	assign u_ext  = {2'b00, cfg.unit_ms};
	assign dur_1u = DUR_W'(u_ext);
	assign dur_2u = DUR_W'(u_ext << 1);
	assign dur_3u = DUR_W'((u_ext << 1) + u_ext);
	assign dur_4u = DUR_W'(u_ext << 2);

	// The output slot is free when empty or being taken this cycle.
	assign adv = !out_valid_q || seg.ready;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		step    = 1'b0;
		key_d   = 1'b0;
		dur_d   = dur_1u;
		last_d  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (q_desc.kind)
						KIND_PREAMBLE: state_d = BK_PRE_ON;
						KIND_SPACE:    state_d = BK_SPACE;
						KIND_PATTERN:  state_d = (q_desc.count == '0) ? BK_GAP : BK_ON;
						default:       state_d = BK_GAP;
					endcase
				end
			end
			BK_PRE_ON: begin
				key_d = 1'b1;
				dur_d = cfg.warmup_on_ms;
				if (adv) begin
					emit    = 1'b1;
					state_d = BK_PRE_OFF;
				end
			end
			BK_PRE_OFF: begin
				dur_d  = cfg.warmup_off_ms;
				last_d = 1'b1;
				if (adv) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_SPACE: begin
				dur_d  = dur_4u;
				last_d = 1'b1;
				if (adv) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_ON: begin
				key_d = 1'b1;
				dur_d = bits_q[0] ? dur_3u : dur_1u;
				if (adv) begin
					emit    = 1'b1;
					state_d = BK_OFF;
				end
			end
			BK_OFF: begin
				dur_d = dur_1u;
				if (adv) begin
					emit    = 1'b1;
					step    = 1'b1;
					state_d = (cnt_q == CNT_W'(1)) ? BK_GAP : BK_ON;
				end
			end
			BK_GAP: begin
				dur_d  = dur_2u;
				last_d = 1'b1;
				if (adv) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (seg.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cnt_q  <= q_desc.count;
			bits_q <= q_desc.bits;
		end else if (step) begin
			cnt_q  <= cnt_q - 1'b1;
			bits_q <= bits_q >> 1;
		end
		if (emit) begin
			key_q  <= key_d;
			dur_q  <= dur_d;
			last_q <= last_d;
		end
	end

	assign seg.valid       = out_valid_q;
	assign seg.key_on      = key_q;
	assign seg.duration_ms = dur_q;
	assign seg.last        = last_q;

endmodule

// ===== sv/morse_keying_sequencer.sv =====
// Top level of the Morse keying sequencer: configuration registers, front end,
// descriptor queue and back end. Depends on mks_pkg, the interfaces and submodules.
//
// Usage: each request on chr carries cmd and char_code. cmd high asks for the
// warm-up preamble (carrier on, then off, for the configured times); otherwise
// the character is keyed in International Morse, lowercase folded to uppercase.
// Each request gives a run of segments on seg (key_on, duration_ms), with last
// set on the final segment of the run. A space gives one four-unit off segment;
// a character with no code gives only the two-unit gap.
// A request is held in the queue, popped into the back-end state and then its
// first segment is registered in the output register that drives seg.
// The back end emits one segment per cycle while seg.ready is high, and fetches
// each descriptor in its idle state between runs; a digit gives the longest run.
// The queue holds two classified requests, so chr keeps accepting while the
// back end is busy. When the receiver holds seg.ready low, the current segment
// stays registered and the back end waits; chr stalls once the queue is full.
// Reset clears the queue and the back end and sets unit_ms to 50, warmup_on_ms
// to 2000 and warmup_off_ms to 1000. Registers are written via cfg_we, cfg_index
// and cfg_data by the user only while the block is idle, which is not enforced.
module morse_keying_sequencer import mks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mks_chr_if.sink               chr,
	mks_seg_if.source             seg,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	desc_t q_wr_desc;
	logic  q_pop;
	logic  q_valid;
	desc_t q_rd_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ms       <= UNIT_RST;
			cfg_q.warmup_on_ms  <= WARMUP_ON_RST;
			cfg_q.warmup_off_ms <= WARMUP_OFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT:       cfg_q.unit_ms       <= cfg_data[UNIT_W-1:0];
				CFG_WARMUP_ON:  cfg_q.warmup_on_ms  <= cfg_data[DUR_W-1:0];
				CFG_WARMUP_OFF: cfg_q.warmup_off_ms <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	mks_front u_front (
		.chr    (chr),
		.q_full (q_full),
		.push   (q_push),
		.desc   (q_wr_desc)
	);

	mks_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_desc  (q_wr_desc),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_desc  (q_rd_desc)
	);

	mks_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_desc  (q_rd_desc),
		.pop     (q_pop),
		.seg     (seg)
	);

endmodule
